// File: rtl/zsmw_pkg.sv
// Shared types and constants for the ZIP stored-member walker.
`default_nettype none
package zsmw_pkg;

	localparam logic [31:0] SIG_LOCAL   = 32'h0403_4b50;
	localparam logic [31:0] SIG_CENTRAL = 32'h0201_4b50;
	localparam logic [31:0] SIG_END     = 32'h0605_4b50;
	localparam logic [15:0] FLAG_MASK   = 16'h0009;
	localparam logic [31:0] CRC_POLY    = 32'hedb8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hffff_ffff;
	localparam logic [15:0] MAX_NAME_LEN = 16'd64;

	localparam logic [4:0] HDR_SIG_LAST = 5'd3;
	localparam logic [4:0] HDR_PRE_LAST = 5'd28;
	localparam logic [4:0] HDR_LAST     = 5'd29;

	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_MEMBER = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [2:0] ERR_SIG      = 3'd0;
	localparam logic [2:0] ERR_FLAGS    = 3'd1;
	localparam logic [2:0] ERR_METHOD   = 3'd2;
	localparam logic [2:0] ERR_SIZE     = 3'd3;
	localparam logic [2:0] ERR_NAME_LEN = 3'd4;
	localparam logic [2:0] ERR_TRUNC    = 3'd5;
	localparam logic [2:0] ERR_OVERFLOW = 3'd6;

	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_char;
		logic [31:0] data_start;
		logic [31:0] member_size;
		logic [31:0] header_crc;
		logic        crc_match;
		logic [2:0]  error_code;
		logic        run_end;
	} res_t;

	// Up to two results per byte; push1 only with push0.
	typedef struct packed {
		logic push0;
		logic push1;
		res_t res0;
		res_t res1;
	} push_t;

endpackage
`default_nettype wire

// File: rtl/zsmw_walker.sv
// Header walker: input register, field capture, checks, CRC-32 and result forming.
`default_nettype none
module zsmw_walker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_load,
	input  wire logic [7:0]      archive_byte,
	input  wire logic            final_byte,
	output zsmw_pkg::push_t      push
);
	import zsmw_pkg::*;

	typedef enum logic [2:0] {PH_HEADER, PH_NAME, PH_EXTRA, PH_DATA, PH_DONE} phase_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
		return r;
	endfunction

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;

	phase_t      phase_q, phase_n;
	logic [4:0]  cnt_q, cnt_n;
	logic [31:0] sig_q, sig_n;
	logic [15:0] flags_q, flags_n;
	logic [15:0] method_q, method_n;
	logic [31:0] hcrc_q, hcrc_n;
	logic [31:0] packed_q, packed_n;
	logic [31:0] plain_q, plain_n;
	logic [15:0] name_q, name_n;
	logic [15:0] extra_q, extra_n;
	logic [31:0] rem_q, rem_n;
	logic [32:0] pos_q, pos_n;
	logic [31:0] crc_q, crc_n;
	// position of data start minus extra length, plus size: taken one byte early
	logic [34:0] part_q, part_n;

	logic [32:0] pos_inc;
	logic [31:0] rem_dec;
	logic [31:0] crc_next;
	logic [31:0] crc_cur;
	logic [34:0] off_sum;
	logic        have_char, member, complete, err_v, restart;
	logic [2:0]  err_c;
	res_t        r_char, r_member, r_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_load;
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			byte_s1 <= archive_byte;
			fin_s1  <= final_byte;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		sig_n    = sig_q;
		flags_n  = flags_q;
		method_n = method_q;
		hcrc_n   = hcrc_q;
		packed_n = packed_q;
		plain_n  = plain_q;
		name_n   = name_q;
		extra_n  = extra_q;
		rem_n    = rem_q;
		pos_n    = pos_q;
		crc_n    = crc_q;
		part_n   = part_q;

		have_char = 1'b0;
		member    = 1'b0;
		complete  = 1'b0;
		err_v     = 1'b0;
		err_c     = ERR_SIG;
		restart   = 1'b0;

		pos_inc  = pos_q + 33'd1;
		rem_dec  = rem_q - 32'd1;
		crc_next = crc_byte(crc_q, byte_s1);
		crc_cur  = (phase_q == PH_DATA) ? crc_next : crc_q;
		off_sum  = part_q + {19'd0, byte_s1, extra_q[7:0]};

		if (v_s1 && phase_q != PH_DONE) begin
			pos_n = pos_inc;
			unique case (phase_q)
				PH_HEADER: begin
					cnt_n = cnt_q + 5'd1;
					case (cnt_q)
						5'd0, 5'd1, 5'd2, 5'd3: sig_n = {byte_s1, sig_q[31:8]};
						5'd6:  flags_n[7:0]    = byte_s1;
						5'd7:  flags_n[15:8]   = byte_s1;
						5'd8:  method_n[7:0]   = byte_s1;
						5'd9:  method_n[15:8]  = byte_s1;
						5'd14: hcrc_n[7:0]     = byte_s1;
						5'd15: hcrc_n[15:8]    = byte_s1;
						5'd16: hcrc_n[23:16]   = byte_s1;
						5'd17: hcrc_n[31:24]   = byte_s1;
						5'd18: packed_n[7:0]   = byte_s1;
						5'd19: packed_n[15:8]  = byte_s1;
						5'd20: packed_n[23:16] = byte_s1;
						5'd21: packed_n[31:24] = byte_s1;
						5'd22: plain_n[7:0]    = byte_s1;
						5'd23: plain_n[15:8]   = byte_s1;
						5'd24: plain_n[23:16]  = byte_s1;
						5'd25: plain_n[31:24]  = byte_s1;
						5'd26: name_n[7:0]     = byte_s1;
						5'd27: name_n[15:8]    = byte_s1;
						5'd28: extra_n[7:0]    = byte_s1;
						5'd29: extra_n[15:8]   = byte_s1;
						default: ;
					endcase
					if (cnt_q == HDR_SIG_LAST) begin
						if (sig_n == SIG_CENTRAL || sig_n == SIG_END) begin
							complete = 1'b1;
						end else if (sig_n != SIG_LOCAL) begin
							err_v = 1'b1;
							err_c = ERR_SIG;
						end
					end
					if (cnt_q == HDR_PRE_LAST) begin
						// position after the last header byte, plus name length and size
						part_n = {2'd0, pos_inc + 33'd1} + {3'd0, packed_q} + {19'd0, name_q};
					end
					if (cnt_q == HDR_LAST) begin
						err_v = 1'b1;
						if ((flags_q & FLAG_MASK) != 16'd0) begin
							err_c = ERR_FLAGS;
						end else if (method_q != 16'd0) begin
							err_c = ERR_METHOD;
						end else if (packed_q != plain_q) begin
							err_c = ERR_SIZE;
						end else if (name_q == 16'd0 || name_q >= MAX_NAME_LEN) begin
							err_c = ERR_NAME_LEN;
						end else if (off_sum[34:32] != 3'd0) begin
							err_c = ERR_OVERFLOW;
						end else begin
							err_v   = 1'b0;
							phase_n = PH_NAME;
							rem_n   = {16'd0, name_q};
							crc_n   = CRC_INIT;
						end
					end
				end
				PH_NAME: begin
					have_char = 1'b1;
					rem_n     = rem_dec;
					if (rem_dec == 32'd0) begin
						if (extra_q != 16'd0) begin
							phase_n = PH_EXTRA;
							rem_n   = {16'd0, extra_q};
						end else if (packed_q != 32'd0) begin
							phase_n = PH_DATA;
							rem_n   = packed_q;
						end else begin
							member = 1'b1;
						end
					end
				end
				PH_EXTRA: begin
					rem_n = rem_dec;
					if (rem_dec == 32'd0) begin
						if (packed_q != 32'd0) begin
							phase_n = PH_DATA;
							rem_n   = packed_q;
						end else begin
							member = 1'b1;
						end
					end
				end
				PH_DATA: begin
					crc_n = crc_next;
					rem_n = rem_dec;
					if (rem_dec == 32'd0)
						member = 1'b1;
				end
				default: ;
			endcase

			if (member)
				restart = 1'b1;
			// an early end replaces a member-done result
			if (fin_s1 && !complete && !err_v) begin
				err_v  = 1'b1;
				err_c  = ERR_TRUNC;
				member = 1'b0;
			end
		end

		if (v_s1 && fin_s1)
			restart = 1'b1;

		if (restart) begin
			phase_n  = PH_HEADER;
			cnt_n    = 5'd0;
			sig_n    = 32'd0;
			flags_n  = 16'd0;
			method_n = 16'd0;
			hcrc_n   = 32'd0;
			packed_n = 32'd0;
			plain_n  = 32'd0;
			name_n   = 16'd0;
			extra_n  = 16'd0;
			rem_n    = 32'd0;
			crc_n    = CRC_INIT;
		end
		if (complete || err_v)
			phase_n = PH_DONE;
		if (v_s1 && fin_s1) begin
			phase_n = PH_HEADER;
			pos_n   = 33'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			cnt_q    <= 5'd0;
			sig_q    <= 32'd0;
			flags_q  <= 16'd0;
			method_q <= 16'd0;
			hcrc_q   <= 32'd0;
			packed_q <= 32'd0;
			plain_q  <= 32'd0;
			name_q   <= 16'd0;
			extra_q  <= 16'd0;
			rem_q    <= 32'd0;
			pos_q    <= 33'd0;
			crc_q    <= CRC_INIT;
			part_q   <= 35'd0;
		end else begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			sig_q    <= sig_n;
			flags_q  <= flags_n;
			method_q <= method_n;
			hcrc_q   <= hcrc_n;
			packed_q <= packed_n;
			plain_q  <= plain_n;
			name_q   <= name_n;
			extra_q  <= extra_n;
			rem_q    <= rem_n;
			pos_q    <= pos_n;
			crc_q    <= crc_n;
			part_q   <= part_n;
		end
	end

	always_comb begin
		r_char           = '0;
		r_char.kind      = KIND_NAME;
		r_char.name_char = byte_s1;

		r_member             = '0;
		r_member.kind        = KIND_MEMBER;
		r_member.data_start  = pos_inc[31:0] - packed_q;
		r_member.member_size = packed_q;
		r_member.header_crc  = hcrc_q;
		r_member.crc_match   = ((~crc_cur) == hcrc_q);

		r_end = '0;
		if (complete) begin
			r_end.kind = KIND_DONE;
		end else begin
			r_end.kind       = KIND_ERROR;
			r_end.error_code = err_c;
		end

		push       = '0;
		push.push0 = have_char || member || complete || err_v;
		push.push1 = have_char && (member || complete || err_v);
		if (have_char)
			push.res0 = r_char;
		else if (member)
			push.res0 = r_member;
		else
			push.res0 = r_end;
		push.res1 = member ? r_member : r_end;
		push.res0.run_end = !push.push1;
		push.res1.run_end = 1'b1;
	end

endmodule
`default_nettype wire

// File: rtl/zsmw_res_queue.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
`default_nettype none
module zsmw_res_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire zsmw_pkg::push_t push,
	output zsmw_pkg::res_t       head,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 room
);
	import zsmw_pkg::*;

	res_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic [QAW-1:0] wp1;
	logic           pop;

	assign wp1       = wp_q + {{(QAW-1){1'b0}}, 1'b1};
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rp_q];
	// the byte in the input register may still add two, the next byte two more
	assign room      = (cnt_q <= (QAW+1)'(QDEPTH - 4));

	always_ff @(posedge clk) begin
		if (push.push0)
			mem_q[wp_q] <= push.res0;
		if (push.push1)
			mem_q[wp1] <= push.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + {{(QAW-1){1'b0}}, push.push0} + {{(QAW-1){1'b0}}, push.push1};
			if (pop)
				rp_q <= rp_q + {{(QAW-1){1'b0}}, 1'b1};
			cnt_q <= cnt_q + {{QAW{1'b0}}, push.push0} + {{QAW{1'b0}}, push.push1}
				- {{QAW{1'b0}}, pop};
		end
	end

endmodule
`default_nettype wire

// File: rtl/zip_stored_member_walker_core.sv
// Top level of the ZIP stored-member walker.
// A byte's results pass the input register and are then written to the result queue;
// a second result of the same byte is handed out by the queue after the first.
// Throughput: one byte per cycle; the eight-entry result queue takes a byte
// while it holds four or fewer results.
// Reset clears the walk state and the queue; a final byte re-arms the walker.
`default_nettype none
module zip_stored_member_walker_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  archive_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       name_char,
	output logic [31:0]      data_start,
	output logic [31:0]      member_size,
	output logic [31:0]      header_crc,
	output logic             crc_match,
	output logic [2:0]       error_code,
	output logic             run_end
);
	import zsmw_pkg::*;

	push_t push;
	res_t  head;
	logic  room;
	logic  in_load;

	assign in_ready = room;
	assign in_load  = in_valid && room;

	zsmw_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_load      (in_load),
		.archive_byte (archive_byte),
		.final_byte   (final_byte),
		.push         (push)
	);

	zsmw_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.head      (head),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.room      (room)
	);

	assign kind        = head.kind;
	assign name_char   = head.name_char;
	assign data_start  = head.data_start;
	assign member_size = head.member_size;
	assign header_crc  = head.header_crc;
	assign crc_match   = head.crc_match;
	assign error_code  = head.error_code;
	assign run_end     = head.run_end;

endmodule
`default_nettype wire

// File: tb/sv/zip_stored_member_walker_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the ZIP stored-member walker: archive streams in, results scoreboarded.
module zip_stored_member_walker_core_test;
	import zsmw_pkg::*;

	localparam int STALL_CYCLES  = 300;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_BYTES  = 1350;

	typedef enum int {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;
	typedef enum logic [2:0] {WALK_HEADER, WALK_NAME, WALK_EXTRA, WALK_DATA, WALK_DONE} walk_t;
	typedef enum int {
		FLAW_NONE, FLAW_FLAGS, FLAW_METHOD, FLAW_SIZE, FLAW_NAME_LEN,
		FLAW_OVERFLOW, FLAW_EXACT_FIT, FLAW_BAD_CRC
	} flaw_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
		pace_t      pace;
		bit         drain_first;
		bit         rx_hold;
	} byte_slot_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  archive_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  name_char;
	logic [31:0] data_start;
	logic [31:0] member_size;
	logic [31:0] header_crc;
	logic        crc_match;
	logic [2:0]  error_code;
	logic        run_end;

	byte_slot_t  archive_feed[$];
	res_t        walk_results_due[$];
	logic [7:0]  arc_bytes[$];

	pace_t       gen_pace = PACE_RX_SLOW;
	bit          gen_drain = 1'b0;
	bit          gen_hold = 1'b0;
	pace_t       pace_now = PACE_RX_SLOW;
	int          hold_requests = 0;
	int          holds_served = 0;
	int          hold_left = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	// walker state as predicted
	walk_t       w_phase;
	logic [4:0]  w_hdr_idx;
	logic [31:0] w_sig, w_crc_field, w_packed, w_plain, w_left, w_crc;
	logic [15:0] w_flags, w_method, w_name_len, w_extra_len;
	logic [32:0] w_pos;

	zip_stored_member_walker_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.archive_byte(archive_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.name_char(name_char),
		.data_start(data_start),
		.member_size(member_size),
		.header_crc(header_crc),
		.crc_match(crc_match),
		.error_code(error_code),
		.run_end(run_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int i = 0; i < 8; i++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic walk_new_header();
		w_phase = WALK_HEADER;
		w_hdr_idx = '0;
		w_sig = '0;
		w_flags = '0;
		w_method = '0;
		w_crc_field = '0;
		w_packed = '0;
		w_plain = '0;
		w_name_len = '0;
		w_extra_len = '0;
		w_left = '0;
		w_crc = CRC_INIT;
	endtask

	// name and extra consumed: go to data, or the member is already complete
	task automatic walk_body_done(output bit member);
		member = 1'b0;
		if (w_packed != 0) begin
			w_phase = WALK_DATA;
			w_left = w_packed;
		end else
			member = 1'b1;
	endtask

	task automatic walk_predict(input logic [7:0] b, input logic fin);
		bit have_char, member, complete, failed, tail;
		logic [2:0] err;
		logic [34:0] data_end;
		res_t r, r_member;
		int k;
		have_char = 1'b0;
		member = 1'b0;
		complete = 1'b0;
		failed = 1'b0;
		err = ERR_SIG;
		r_member = '0;
		if (w_phase == WALK_DONE) begin
			if (fin) begin
				walk_new_header();
				w_pos = '0;
			end
			return;
		end
		w_pos = w_pos + 33'd1;
		case (w_phase)
		WALK_HEADER: begin
			k = int'(w_hdr_idx);
			if (k < 4)
				w_sig = {b, w_sig[31:8]};
			else if (k >= 6 && k < 8)
				w_flags[8*(k-6) +: 8] = b;
			else if (k >= 8 && k < 10)
				w_method[8*(k-8) +: 8] = b;
			else if (k >= 14 && k < 18)
				w_crc_field[8*(k-14) +: 8] = b;
			else if (k >= 18 && k < 22)
				w_packed[8*(k-18) +: 8] = b;
			else if (k >= 22 && k < 26)
				w_plain[8*(k-22) +: 8] = b;
			else if (k >= 26 && k < 28)
				w_name_len[8*(k-26) +: 8] = b;
			else if (k >= 28)
				w_extra_len[8*(k-28) +: 8] = b;
			w_hdr_idx = w_hdr_idx + 5'd1;
			if (k == HDR_SIG_LAST) begin
				if (w_sig == SIG_CENTRAL || w_sig == SIG_END)
					complete = 1'b1;
				else if (w_sig != SIG_LOCAL) begin
					failed = 1'b1;
					err = ERR_SIG;
				end
			end else if (k == HDR_LAST) begin
				data_end = {2'b00, w_pos} + {19'h0, w_name_len} + {19'h0, w_extra_len}
					+ {3'h0, w_packed};
				failed = 1'b1;
				if ((w_flags & FLAG_MASK) != 0)
					err = ERR_FLAGS;
				else if (w_method != 0)
					err = ERR_METHOD;
				else if (w_packed != w_plain)
					err = ERR_SIZE;
				else if (w_name_len == 0 || w_name_len >= MAX_NAME_LEN)
					err = ERR_NAME_LEN;
				else if (data_end > 35'h0_FFFF_FFFF)
					err = ERR_OVERFLOW;
				else begin
					failed = 1'b0;
					w_phase = WALK_NAME;
					w_left = {16'h0, w_name_len};
					w_crc = CRC_INIT;
				end
			end
		end
		WALK_NAME: begin
			have_char = 1'b1;
			w_left = w_left - 32'd1;
			if (w_left == 0) begin
				if (w_extra_len != 0) begin
					w_phase = WALK_EXTRA;
					w_left = {16'h0, w_extra_len};
				end else
					walk_body_done(member);
			end
		end
		WALK_EXTRA: begin
			w_left = w_left - 32'd1;
			if (w_left == 0)
				walk_body_done(member);
		end
		default: begin
			w_crc = crc32_byte(w_crc, b);
			w_left = w_left - 32'd1;
			if (w_left == 0)
				member = 1'b1;
		end
		endcase

		if (member) begin
			r_member.kind = KIND_MEMBER;
			r_member.data_start = w_pos[31:0] - w_packed;
			r_member.member_size = w_packed;
			r_member.header_crc = w_crc_field;
			r_member.crc_match = (~w_crc == w_crc_field);
			walk_new_header();
		end
		// an early end replaces the member report of the same byte
		if (fin && !complete && !failed) begin
			failed = 1'b1;
			err = ERR_TRUNC;
			member = 1'b0;
		end
		tail = complete || failed;
		if (tail)
			w_phase = WALK_DONE;

		if (have_char) begin
			r = '0;
			r.kind = KIND_NAME;
			r.name_char = b;
			r.run_end = !member && !tail;
			walk_results_due.push_back(r);
		end
		if (member) begin
			r_member.run_end = !tail;
			walk_results_due.push_back(r_member);
		end
		if (tail) begin
			r = '0;
			r.kind = complete ? KIND_DONE : KIND_ERROR;
			if (!complete)
				r.error_code = err;
			r.run_end = 1'b1;
			walk_results_due.push_back(r);
		end
		if (fin) begin
			walk_new_header();
			w_pos = '0;
		end
	endtask

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			arc_bytes.push_back(v[8*i +: 8]);
	endtask

	// send the first keep bytes of the built archive, the last one flagged final
	task automatic feed_archive(input int keep);
		byte_slot_t slot;
		for (int i = 0; i < keep; i++) begin
			slot.value = arc_bytes[i];
			slot.last = (i == keep - 1);
			slot.pace = gen_pace;
			slot.drain_first = gen_drain;
			slot.rx_hold = gen_hold;
			gen_drain = 1'b0;
			gen_hold = 1'b0;
			archive_feed.push_back(slot);
		end
		arc_bytes.delete();
	endtask

	// one local header plus body; stops is set when the walk cannot pass this member
	task automatic add_member(input flaw_t flaw, input logic [15:0] nlen_in,
			input logic [15:0] xlen, input int dlen, output bit stops);
		logic [15:0] flags, method, nlen;
		logic [31:0] crc, psize, usize, base;
		logic [7:0] data[$];
		nlen = nlen_in;
		flags = ($urandom_range(1) == 0) ? 16'h0000 : (16'($urandom()) & ~FLAG_MASK);
		method = 16'h0000;
		crc = CRC_INIT;
		for (int i = 0; i < dlen; i++) begin
			data.push_back(8'($urandom_range(255)));
			crc = crc32_byte(crc, data[i]);
		end
		crc = ~crc;
		psize = dlen;
		usize = dlen;
		stops = (flaw != FLAW_NONE && flaw != FLAW_BAD_CRC);
		case (flaw)
		FLAW_FLAGS:
			flags = flags | (($urandom_range(1) == 0) ? 16'h0001 : 16'h0008);
		FLAW_METHOD:
			method = 16'($urandom_range(1, 65535));
		FLAW_SIZE:
			usize = psize ^ (32'h1 << $urandom_range(31));
		FLAW_NAME_LEN:
			case ($urandom_range(2))
			0: nlen = 16'd0;
			1: nlen = MAX_NAME_LEN;
			default: nlen = 16'($urandom_range(65, 65535));
			endcase
		FLAW_OVERFLOW, FLAW_EXACT_FIT: begin
			base = arc_bytes.size() + 30 + {16'h0, nlen} + {16'h0, xlen};
			psize = 32'hFFFF_FFFF - base;
			if (flaw == FLAW_OVERFLOW)
				psize = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : psize + $urandom_range(1, 64);
			usize = psize;
		end
		FLAW_BAD_CRC:
			crc = crc ^ ($urandom() | 32'h1);
		default: ;
		endcase
		put_le(SIG_LOCAL, 4);
		put_le($urandom(), 2);
		put_le({16'h0, flags}, 2);
		put_le({16'h0, method}, 2);
		put_le($urandom(), 4);
		put_le(crc, 4);
		put_le(psize, 4);
		put_le(usize, 4);
		put_le({16'h0, nlen}, 2);
		put_le({16'h0, xlen}, 2);
		if (stops && flaw != FLAW_EXACT_FIT)
			return;
		repeat (nlen) arc_bytes.push_back(8'($urandom_range(255)));
		repeat (xlen) arc_bytes.push_back(8'($urandom_range(255)));
		if (flaw == FLAW_EXACT_FIT) begin
			repeat ($urandom_range(1, 4)) arc_bytes.push_back(8'($urandom_range(255)));
			return;
		end
		foreach (data[i])
			arc_bytes.push_back(data[i]);
	endtask

	task automatic add_random_archive();
		int unsigned pick, members, dlen;
		logic [15:0] nlen, xlen;
		bit stops;
		flaw_t flaw;
		pick = $urandom_range(99);
		if (pick < 12) begin
			repeat ($urandom_range(1, 12)) arc_bytes.push_back(8'($urandom_range(255)));
			feed_archive(arc_bytes.size());
		end else if (pick < 22) begin
			// valid signature over a random header
			put_le(SIG_LOCAL, 4);
			repeat ($urandom_range(1, 40)) arc_bytes.push_back(8'($urandom_range(255)));
			feed_archive(arc_bytes.size());
		end else begin
			members = $urandom_range(0, 3);
			stops = 1'b0;
			for (int m = 0; m < members && !stops; m++) begin
				pick = $urandom_range(99);
				if (pick < 70)
					flaw = FLAW_NONE;
				else if (pick < 80)
					flaw = FLAW_BAD_CRC;
				else
					flaw = flaw_t'($urandom_range(FLAW_FLAGS, FLAW_EXACT_FIT));
				nlen = ($urandom_range(15) == 0) ? MAX_NAME_LEN - 16'd1
					: 16'($urandom_range(1, 6));
				xlen = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 4)) : 16'd0;
				dlen = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				add_member(flaw, nlen, xlen, dlen, stops);
			end
			if (!stops)
				put_le(($urandom_range(1) == 0) ? SIG_CENTRAL : SIG_END, 4);
			repeat ($urandom_range(0, 6)) arc_bytes.push_back(8'($urandom_range(255)));
			if ($urandom_range(9) == 0)
				feed_archive($urandom_range(1, arc_bytes.size()));
			else
				feed_archive(arc_bytes.size());
		end
	endtask

	task automatic report_result(input string what, input res_t want, input res_t seen);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s exp: kind=%0d chr=%h start=%h size=%h crc=%h ok=%b err=%0d end=%b",
				what, want.kind, want.name_char, want.data_start, want.member_size,
				want.header_crc, want.crc_match, want.error_code, want.run_end);
			$display("%s got: kind=%0d chr=%h start=%h size=%h crc=%h ok=%b err=%0d end=%b",
				what, seen.kind, seen.name_char, seen.data_start, seen.member_size,
				seen.header_crc, seen.crc_match, seen.error_code, seen.run_end);
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin : feed_driver
		byte_slot_t slot;
		int unsigned idle_pct;
		if (!arst_n) begin
			in_valid <= 1'b0;
			archive_byte <= 8'h00;
			final_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				walk_predict(archive_byte, final_byte);
			idle_pct = 0;
			if (archive_feed.size() != 0)
				case (archive_feed[0].pace)
				PACE_RX_SLOW: idle_pct = 22;
				PACE_TX_SLOW: idle_pct = 68;
				default: idle_pct = 0;
				endcase
			if (in_valid && !in_ready) begin
				// hold the byte until its transfer
			end else if (archive_feed.size() != 0 &&
					!(archive_feed[0].drain_first && walk_results_due.size() != 0) &&
					$urandom_range(99) >= idle_pct) begin
				slot = archive_feed.pop_front();
				in_valid <= 1'b1;
				archive_byte <= slot.value;
				final_byte <= slot.last;
				pace_now <= slot.pace;
				if (slot.rx_hold)
					hold_requests <= hold_requests + 1;
			end else
				in_valid <= 1'b0;
		end
	end

	// result monitor and receiver pacing
	always @(posedge clk or negedge arst_n) begin : result_monitor
		res_t seen, want;
		int unsigned idle_pct;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen.kind = kind;
				seen.name_char = name_char;
				seen.data_start = data_start;
				seen.member_size = member_size;
				seen.header_crc = header_crc;
				seen.crc_match = crc_match;
				seen.error_code = error_code;
				seen.run_end = run_end;
				if (walk_results_due.size() == 0)
					report_result("unexpected", '0, seen);
				else begin
					want = walk_results_due.pop_front();
					if (seen !== want)
						report_result("mismatch", want, seen);
				end
			end
			case (pace_now)
			PACE_RX_SLOW: idle_pct = 68;
			PACE_TX_SLOW: idle_pct = 22;
			default: idle_pct = 0;
			endcase
			if (holds_served != hold_requests) begin
				holds_served <= hold_requests;
				hold_left <= STALL_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		bit stops;
		int start;
		walk_new_header();
		w_pos = '0;

		// directory or end record right at the start
		put_le(SIG_CENTRAL, 4);
		feed_archive(4);
		put_le(SIG_END, 4);
		arc_bytes.push_back(8'h00);
		arc_bytes.push_back(8'hFF);
		feed_archive(arc_bytes.size());
		// bad signature ending on the final byte, then a lone final byte
		put_le(32'hFFFF_FFFF, 4);
		feed_archive(4);
		arc_bytes.push_back(8'h00);
		feed_archive(1);

		// check value of "123456789" is cbf43926
		put_le(SIG_LOCAL, 4);
		put_le(0, 2);
		put_le(0, 2);
		put_le(0, 2);
		put_le(0, 4);
		put_le(32'hCBF4_3926, 4);
		put_le(9, 4);
		put_le(9, 4);
		put_le(1, 2);
		put_le(0, 2);
		arc_bytes.push_back(8'h61);
		for (int i = 0; i < 9; i++)
			arc_bytes.push_back(8'(8'h31 + i));
		put_le(SIG_END, 4);
		feed_archive(arc_bytes.size());

		// each header rejection, plus a data end exactly at the 32-bit limit
		for (int f = FLAW_FLAGS; f <= FLAW_EXACT_FIT; f++) begin
			add_member(flaw_t'(f), 16'd2, 16'd1, 3, stops);
			feed_archive(arc_bytes.size());
		end

		// longest name with extra and no data, then a CRC miss
		add_member(FLAW_NONE, MAX_NAME_LEN - 16'd1, 16'd3, 0, stops);
		add_member(FLAW_BAD_CRC, 16'd1, 16'd0, 5, stops);
		put_le(SIG_CENTRAL, 4);
		feed_archive(arc_bytes.size());

		// archive ends on the last name byte of an empty member
		add_member(FLAW_NONE, 16'd2, 16'd0, 0, stops);
		feed_archive(arc_bytes.size());

		start = archive_feed.size();
		for (int p = PACE_RX_SLOW; p <= PACE_FULL; p++) begin
			gen_pace = pace_t'(p);
			gen_drain = 1'b1;
			gen_hold = (p != PACE_TX_SLOW);
			while (archive_feed.size() - start < RANDOM_BYTES * (p + 1) / 3)
				add_random_archive();
		end

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		while (archive_feed.size() != 0 || in_valid)
			@(negedge clk);
		while (walk_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		mismatch_count += walk_results_due.size();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
